/* rtl/cpfm_pkg.sv */
package cpfm_pkg;

  // Table geometry and field widths.
  localparam int FRAMES = 32;
  localparam int FRAME_W = 5;
  localparam int PROC_W = 4;
  localparam int PAGE_W = 4;
  localparam int LOCK_W = 4;
  localparam int COUNT_W = 6;
  localparam int VISIT_W = 7;
  localparam int EVICT_W = 4;
  localparam int KIND_W = 3;

  localparam logic [LOCK_W-1:0] LOCK_MAX = '1;
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAMES - 1);
  localparam logic [VISIT_W-1:0] VISIT_LIMIT = VISIT_W'(2 * FRAMES);
  localparam logic [EVICT_W-1:0] EVICT_MAX = EVICT_W'(8);
  localparam logic [COUNT_W-1:0] WM_RESET = COUNT_W'(7);
  localparam logic [EVICT_W-1:0] SWEEP_RESET = EVICT_W'(3);

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REF = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOCK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNLOCK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_RESIDENT = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;
  localparam logic [1:0] ST_RESIDENT = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_LOW_WM = 1'b0;
  localparam logic CFG_PER_SWEEP = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PROC_W-1:0] process_id;
    logic [PAGE_W-1:0] page_number;
    logic              is_store;
    logic              io_into_memory;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_eviction;
    logic [FRAME_W-1:0] frame_number;
    logic [PROC_W-1:0]  victim_process;
    logic [PAGE_W-1:0]  victim_page;
    logic               needs_writeback;
    logic [COUNT_W-1:0] released_count;
    logic [COUNT_W-1:0] free_frames;
    logic               last;
  } out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_SWEEP,
    OP_FIND,
    OP_FINAL,
    OP_FIN_ALLOC
  } op_t;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_HAND,
    ADDR_FOUND
  } addr_sel_t;

  typedef struct packed {
    op_t       op;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic              avail;
    logic              idx_last;
    logic              below_wm;
    logic              sweep_end;
    logic              slot_free;
  } stat_t;

endpackage

/* rtl/cpfm_ctrl.sv */
module cpfm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpfm_pkg::stat_t stat,
  output cpfm_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_FIND,
    S_FIN,
    S_FIN_ALLOC
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd.op = cpfm_pkg::OP_NONE;
    cmd.addr_sel = cpfm_pkg::ADDR_IDX;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = cpfm_pkg::OP_LOAD;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.kind > cpfm_pkg::KIND_RELEASE) begin
          state_next = S_FIN;
        end else begin
          cmd.op = cpfm_pkg::OP_SCAN;
          if (stat.kind != cpfm_pkg::KIND_RELEASE && stat.hit) begin
            state_next = S_FIN;
          end else if (stat.idx_last) begin
            if (stat.kind != cpfm_pkg::KIND_ALLOC) begin
              state_next = S_FIN;
            end else if (stat.below_wm) begin
              state_next = S_SWEEP;
            end else begin
              state_next = S_FIND;
            end
          end
        end
      end
      S_SWEEP: begin
        cmd.addr_sel = cpfm_pkg::ADDR_HAND;
        if (stat.sweep_end) begin
          state_next = S_FIND;
        end else if (stat.slot_free) begin
          cmd.op = cpfm_pkg::OP_SWEEP;
        end
      end
      S_FIND: begin
        cmd.op = cpfm_pkg::OP_FIND;
        if (stat.avail || stat.idx_last) begin
          state_next = S_FIN_ALLOC;
        end
      end
      S_FIN: begin
        cmd.addr_sel = cpfm_pkg::ADDR_FOUND;
        if (stat.slot_free) begin
          cmd.op = cpfm_pkg::OP_FINAL;
          state_next = S_IDLE;
        end
      end
      S_FIN_ALLOC: begin
        cmd.addr_sel = cpfm_pkg::ADDR_FOUND;
        if (stat.slot_free) begin
          cmd.op = cpfm_pkg::OP_FIN_ALLOC;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/cpfm_dp.sv */
module cpfm_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  cpfm_pkg::in_t                  in_data,
  output cpfm_pkg::out_t                 out_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           wr_en,
  input  logic                           wr_index,
  input  logic [cpfm_pkg::COUNT_W-1:0]   wr_data,
  input  cpfm_pkg::cmd_t                 cmd,
  output cpfm_pkg::stat_t                stat
);

  // Frame table.
  logic                          frame_free  [cpfm_pkg::FRAMES];
  logic [cpfm_pkg::PROC_W-1:0]   frame_owner [cpfm_pkg::FRAMES];
  logic [cpfm_pkg::PAGE_W-1:0]   frame_page  [cpfm_pkg::FRAMES];
  logic                          frame_dirty [cpfm_pkg::FRAMES];
  logic                          frame_ref   [cpfm_pkg::FRAMES];
  logic [cpfm_pkg::LOCK_W-1:0]   frame_locks [cpfm_pkg::FRAMES];

  logic [cpfm_pkg::FRAME_W-1:0]  hand;
  logic [cpfm_pkg::COUNT_W-1:0]  free_count;
  logic [cpfm_pkg::COUNT_W-1:0]  low_wm;
  logic [cpfm_pkg::EVICT_W-1:0]  per_sweep;

  cpfm_pkg::in_t                 item;
  logic [cpfm_pkg::FRAME_W-1:0]  idx;
  logic [cpfm_pkg::FRAME_W-1:0]  found_idx;
  logic                          found;
  logic [cpfm_pkg::COUNT_W-1:0]  cnt;
  logic [cpfm_pkg::EVICT_W-1:0]  done;
  logic [cpfm_pkg::VISIT_W-1:0]  visits;

  logic [cpfm_pkg::FRAME_W-1:0]  addr;
  logic                          c_free;
  logic [cpfm_pkg::PROC_W-1:0]   c_owner;
  logic [cpfm_pkg::PAGE_W-1:0]   c_page;
  logic                          c_dirty;
  logic                          c_ref;
  logic [cpfm_pkg::LOCK_W-1:0]   c_locks;
  logic                          hit;
  logic                          owned;
  logic                          avail;
  logic [cpfm_pkg::EVICT_W-1:0]  target;

  logic                          tw;
  logic                          w_free;
  logic [cpfm_pkg::PROC_W-1:0]   w_owner;
  logic [cpfm_pkg::PAGE_W-1:0]   w_page;
  logic                          w_dirty;
  logic                          w_ref;
  logic [cpfm_pkg::LOCK_W-1:0]   w_locks;
  logic [cpfm_pkg::COUNT_W-1:0]  free_count_next;
  logic                          out_load;
  cpfm_pkg::out_t                out_next;

  // Single table read port, shared by scan, sweep, free-frame search and final update.
  always_comb begin
    case (cmd.addr_sel)
      cpfm_pkg::ADDR_HAND:  addr = hand;
      cpfm_pkg::ADDR_FOUND: addr = found_idx;
      default:              addr = idx;
    endcase
    c_free = frame_free[addr];
    c_owner = frame_owner[addr];
    c_page = frame_page[addr];
    c_dirty = frame_dirty[addr];
    c_ref = frame_ref[addr];
    c_locks = frame_locks[addr];
    owned = !c_free && c_owner == item.process_id;
    hit = owned && c_page == item.page_number;
    avail = c_free && c_locks == '0;
    target = (per_sweep > cpfm_pkg::EVICT_MAX) ? cpfm_pkg::EVICT_MAX : per_sweep;
  end

  assign stat.kind = item.kind;
  assign stat.hit = hit;
  assign stat.avail = avail;
  assign stat.idx_last = idx == cpfm_pkg::FRAME_LAST;
  assign stat.below_wm = free_count < low_wm;
  assign stat.sweep_end = done == target || visits == cpfm_pkg::VISIT_LIMIT;
  assign stat.slot_free = !out_valid || out_ready;

  // Per-operation table update and result formation.
  always_comb begin
    tw = 1'b0;
    w_free = c_free;
    w_owner = c_owner;
    w_page = c_page;
    w_dirty = c_dirty;
    w_ref = c_ref;
    w_locks = c_locks;
    free_count_next = free_count;
    out_load = 1'b0;
    out_next = '0;
    case (cmd.op)
      cpfm_pkg::OP_SCAN: begin
        if (item.kind == cpfm_pkg::KIND_RELEASE && owned) begin
          tw = 1'b1;
          w_free = 1'b1;
          w_owner = '0;
          w_page = '0;
          w_dirty = 1'b0;
          w_ref = 1'b0;
          free_count_next = free_count + 1'b1;
        end
      end
      cpfm_pkg::OP_SWEEP: begin
        if (!c_free && c_locks == '0) begin
          tw = 1'b1;
          if (c_ref) begin
            w_ref = 1'b0;
          end else begin
            w_free = 1'b1;
            w_owner = '0;
            w_page = '0;
            w_dirty = 1'b0;
            free_count_next = free_count + 1'b1;
            out_load = 1'b1;
            out_next.status = cpfm_pkg::ST_OK;
            out_next.is_eviction = 1'b1;
            out_next.frame_number = addr;
            out_next.victim_process = c_owner;
            out_next.victim_page = c_page;
            out_next.needs_writeback = c_dirty;
          end
        end
      end
      cpfm_pkg::OP_FIN_ALLOC: begin
        out_load = 1'b1;
        out_next.last = 1'b1;
        if (found) begin
          tw = 1'b1;
          w_free = 1'b0;
          w_owner = item.process_id;
          w_page = item.page_number;
          w_dirty = 1'b0;
          w_ref = 1'b0;
          if (free_count != '0) begin
            free_count_next = free_count - 1'b1;
          end
          out_next.frame_number = found_idx;
        end else begin
          out_next.status = cpfm_pkg::ST_NO_FREE;
        end
      end
      cpfm_pkg::OP_FINAL: begin
        out_load = 1'b1;
        out_next.last = 1'b1;
        case (item.kind)
          cpfm_pkg::KIND_ALLOC: begin
            out_next.status = cpfm_pkg::ST_RESIDENT;
            out_next.frame_number = found_idx;
          end
          cpfm_pkg::KIND_REF, cpfm_pkg::KIND_LOCK, cpfm_pkg::KIND_UNLOCK: begin
            if (found) begin
              tw = 1'b1;
              out_next.frame_number = found_idx;
              if (item.kind == cpfm_pkg::KIND_REF) begin
                w_ref = 1'b1;
                w_dirty = c_dirty | item.is_store;
              end else if (item.kind == cpfm_pkg::KIND_LOCK) begin
                w_dirty = c_dirty | item.io_into_memory;
                if (c_locks != cpfm_pkg::LOCK_MAX) begin
                  w_locks = c_locks + 1'b1;
                end
              end else if (c_locks != '0) begin
                w_locks = c_locks - 1'b1;
              end
            end else begin
              out_next.status = cpfm_pkg::ST_NOT_RESIDENT;
            end
          end
          cpfm_pkg::KIND_RELEASE: begin
            out_next.released_count = cnt;
          end
          default: begin
            out_next.status = cpfm_pkg::ST_OK;
          end
        endcase
      end
      default: begin
        tw = 1'b0;
      end
    endcase
    out_next.free_frames = free_count_next;
  end

  // Table, counters, configuration and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < cpfm_pkg::FRAMES; f++) begin
        frame_free[f] <= 1'b1;
        frame_owner[f] <= '0;
        frame_page[f] <= '0;
        frame_dirty[f] <= 1'b0;
        frame_ref[f] <= 1'b0;
        frame_locks[f] <= '0;
      end
      hand <= '0;
      free_count <= cpfm_pkg::COUNT_W'(cpfm_pkg::FRAMES);
      low_wm <= cpfm_pkg::WM_RESET;
      per_sweep <= cpfm_pkg::SWEEP_RESET;
      out_valid <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      found_idx <= '0;
      cnt <= '0;
      done <= '0;
      visits <= '0;
    end else begin
      if (tw) begin
        frame_free[addr] <= w_free;
        frame_owner[addr] <= w_owner;
        frame_page[addr] <= w_page;
        frame_dirty[addr] <= w_dirty;
        frame_ref[addr] <= w_ref;
        frame_locks[addr] <= w_locks;
      end
      free_count <= free_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        if (wr_index == cpfm_pkg::CFG_LOW_WM) begin
          low_wm <= wr_data;
        end else if (wr_index == cpfm_pkg::CFG_PER_SWEEP) begin
          per_sweep <= wr_data[cpfm_pkg::EVICT_W-1:0];
        end
      end
      case (cmd.op)
        cpfm_pkg::OP_LOAD: begin
          idx <= '0;
          found <= 1'b0;
          cnt <= '0;
          done <= '0;
          visits <= '0;
        end
        cpfm_pkg::OP_SCAN: begin
          idx <= idx + 1'b1;
          if (item.kind == cpfm_pkg::KIND_RELEASE) begin
            if (owned) begin
              cnt <= cnt + 1'b1;
            end
          end else if (hit) begin
            found <= 1'b1;
            found_idx <= idx;
          end
        end
        cpfm_pkg::OP_SWEEP: begin
          hand <= hand + 1'b1;
          visits <= visits + 1'b1;
          if (out_load) begin
            done <= done + 1'b1;
          end
        end
        cpfm_pkg::OP_FIND: begin
          idx <= idx + 1'b1;
          if (avail) begin
            found <= 1'b1;
            found_idx <= idx;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.op == cpfm_pkg::OP_LOAD) begin
      item <= in_data;
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

/* rtl/clock_page_frame_manager.sv */
// A request visits the table one frame at a time through its single port; an allocation
// scans up to 32 frames for residency, sweeps up to 64 frames, then up to 32 for a free one.
// The block takes one request at a time and accepts no new one until it is finished.
// A finished result waits in an output register; the sweep pauses while that register is full.
// Reset (synchronous, active high) frees every frame, zeroes the hand, sets 32 free frames,
// and restores the low watermark to 7 and the frames per sweep to 3.
module clock_page_frame_manager (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cpfm_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cpfm_pkg::out_t               out_data,
  input  logic                         wr_en,
  input  logic                         wr_index,
  input  logic [cpfm_pkg::COUNT_W-1:0] wr_data
);

  cpfm_pkg::cmd_t  cmd;
  cpfm_pkg::stat_t stat;

  // Sequencer.
  cpfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Frame table and result path.
  cpfm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef ASSERT_OFF
  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in progress");

  // Eviction results are never the final result of a request.
  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_eviction |-> !out_data.last && out_data.status == cpfm_pkg::ST_OK)
    else $error("eviction result marked final or with bad status");

  // The free frame count never exceeds the table size.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.free_frames <= cpfm_pkg::COUNT_W'(cpfm_pkg::FRAMES))
    else $error("free frame count out of range");
`endif

endmodule
